// ===== design/tft_pkg.sv =====
// Package for the TCP flow table tracker: status codes, slot entry type.
// No dependencies.
`default_nettype none
package tft_pkg;
   localparam logic [3:0] ST_BAD_IP  = 4'd0;
   localparam logic [3:0] ST_BAD_TCP = 4'd1;
   localparam logic [3:0] ST_OPENED  = 4'd2;
   localparam logic [3:0] ST_FULL    = 4'd3;
   localparam logic [3:0] ST_SYNACK  = 4'd4;
   localparam logic [3:0] ST_FIN     = 4'd5;
   localparam logic [3:0] ST_SEGMENT = 4'd6;
   localparam logic [3:0] ST_CLOSED  = 4'd7;
   localparam logic [3:0] ST_NOMATCH = 4'd8;

   localparam logic [7:0] FLAGS_SYN    = 8'h02;
   localparam logic [7:0] FLAGS_SYNACK = 8'h12;
   localparam logic [5:0] MIN_HDR      = 6'd20;
   localparam logic [31:0] HDR_BYTES   = 32'd20;

   typedef struct packed {
      logic [31:0] flow_id;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq;
      logic [31:0] ack;
      logic [31:0] up;
      logic [31:0] down;
      logic [31:0] start_time;
      logic [1:0]  fin_count;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);
endpackage
`default_nettype wire

// ===== design/tcp_flow_table_tracker.sv =====
// Top level of the TCP flow table tracker: scan sequencer, slot RAM, valid bits.
// Depends on tft_pkg and tft_ram.
//
// One packet is taken while busy is low; its result appears on the rsp_ ports
// for one cycle, flagged by rsp_valid, and cannot be stalled. Bad headers and
// SYNs are answered from the check state without a RAM read (the free slot is
// found from the valid flops). Every other packet scans all MAX_FLOWS slots of
// the slot RAM, one read per cycle, then, if a slot matched, does one
// read-modify-write; if none matched it answers with no match. A new packet
// can be taken in the cycle its predecessor's result is out.
`default_nettype none
module tcp_flow_table_tracker #(
   parameter int MAX_FLOWS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_ip_header_words,
   input  wire logic [3:0]  req_tcp_data_offset,
   input  wire logic [15:0] req_ip_total_length,
   input  wire logic [31:0] req_source_address,
   input  wire logic [31:0] req_dest_address,
   input  wire logic [15:0] req_source_port,
   input  wire logic [15:0] req_dest_port,
   input  wire logic [7:0]  req_tcp_flag_bits,
   input  wire logic [31:0] req_sequence_number,
   input  wire logic [31:0] req_ack_number,
   input  wire logic [31:0] req_timestamp_s,
   output logic             rsp_valid,
   output logic [3:0]       rsp_status,
   output logic [31:0]      rsp_flow_number,
   output logic [31:0]      rsp_record_source_address,
   output logic [31:0]      rsp_record_dest_address,
   output logic [15:0]      rsp_record_source_port,
   output logic [15:0]      rsp_record_dest_port,
   output logic [31:0]      rsp_duration_s,
   output logic [31:0]      rsp_bytes_up_total,
   output logic [31:0]      rsp_bytes_down_total
);
   localparam int AW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
   localparam int RD = (MAX_FLOWS > 1) ? MAX_FLOWS : 2;
   localparam logic [AW:0] LAST = (AW+1)'(MAX_FLOWS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_MOD   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [RD-1:0] valid_ff, valid_in;
   logic [31:0] next_id_ff, next_id_in;

   // captured request
   logic [3:0]  ihl_ff, thl_ff;
   logic [15:0] tot_ff;
   logic [31:0] sa_ff, da_ff, seq_ff, ack_ff, now_ff;
   logic [15:0] sp_ff, dp_ff;
   logic [7:0]  flg_ff;

   // scan
   logic [AW:0] rcnt_ff, rcnt_in;    // read address issued
   logic [AW-1:0] cidx_ff, cidx_in;  // index of the data now on rdata
   logic        cval_ff, cval_in;    // rdata holds a scan entry
   logic        found_ff, found_in;
   logic [AW-1:0] best_ff, best_in;
   logic [31:0] bage_ff, bage_in;
   logic        bfwd_ff, bfwd_in;

   // response
   logic        rv_ff, rv_in;
   logic [3:0]  rst_ff, rst_in;
   logic [31:0] rfn_ff, rfn_in, rsa_ff, rsa_in, rda_ff, rda_in;
   logic [15:0] rsp_ff, rsp_in, rdp_ff, rdp_in;
   logic [31:0] rdur_ff, rdur_in, rup_ff, rup_in, rdn_ff, rdn_in;

   // ram
   logic we;
   logic [AW-1:0] waddr, raddr;
   tft_pkg::slot_type wdata, rdata;
   logic [tft_pkg::SLOT_W-1:0] rdata_v;

   tft_ram #(.WIDTH(tft_pkg::SLOT_W), .DEPTH(RD)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata_v)
   );
   assign rdata = tft_pkg::slot_type'(rdata_v);

   // lowest free slot
   logic          free_any;
   logic [AW-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = MAX_FLOWS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   logic [5:0] ihl_b, thl_b;
   logic signed [17:0] payload;
   logic is_synack, is_fin;
   logic fwd_m, rev_m, hit;
   logic [31:0] age;
   assign ihl_b = {ihl_ff, 2'b00};
   assign thl_b = {thl_ff, 2'b00};
   assign payload = $signed({2'b00, tot_ff}) -
                    $signed({11'd0, {1'b0, ihl_b} + {1'b0, thl_b}});
   assign is_synack = (flg_ff == tft_pkg::FLAGS_SYNACK);
   assign is_fin = flg_ff[0];
   assign fwd_m = rdata.src_addr == sa_ff && rdata.dst_addr == da_ff &&
                  rdata.src_port == sp_ff && rdata.dst_port == dp_ff;
   assign rev_m = rdata.src_addr == da_ff && rdata.dst_addr == sa_ff &&
                  rdata.src_port == dp_ff && rdata.dst_port == sp_ff;
   assign hit = cval_ff && valid_ff[cidx_ff] && (is_synack ? rev_m : (fwd_m || rev_m));
   assign age = next_id_ff - rdata.flow_id;

   tft_pkg::slot_type upd;
   logic [31:0] addv;
   always_comb begin
      state_in = state_ff; valid_in = valid_ff; next_id_in = next_id_ff;
      rcnt_in = rcnt_ff; cidx_in = cidx_ff; cval_in = 1'b0;
      found_in = found_ff; best_in = best_ff; bage_in = bage_ff; bfwd_in = bfwd_ff;
      rv_in = 1'b0; rst_in = rst_ff; rfn_in = rfn_ff; rsa_in = rsa_ff; rda_in = rda_ff;
      rsp_in = rsp_ff; rdp_in = rdp_ff; rdur_in = rdur_ff; rup_in = rup_ff; rdn_in = rdn_ff;
      we = 1'b0; waddr = best_ff; wdata = rdata; raddr = rcnt_ff[AW-1:0];
      upd = rdata; addv = '0;
      case (state_ff)
         S_IDLE: if (start) state_in = S_CHECK;
         S_CHECK: begin
            rfn_in = '0; rsa_in = '0; rda_in = '0; rsp_in = '0; rdp_in = '0;
            rdur_in = '0; rup_in = '0; rdn_in = '0;
            if (ihl_b < tft_pkg::MIN_HDR) begin
               rst_in = tft_pkg::ST_BAD_IP; rv_in = 1'b1; state_in = S_IDLE;
            end else if (thl_b < tft_pkg::MIN_HDR) begin
               rst_in = tft_pkg::ST_BAD_TCP; rv_in = 1'b1; state_in = S_IDLE;
            end else if (flg_ff == tft_pkg::FLAGS_SYN) begin
               rv_in = 1'b1; state_in = S_IDLE;
               if (!free_any) begin
                  rst_in = tft_pkg::ST_FULL;
               end else begin
                  rst_in = tft_pkg::ST_OPENED; rfn_in = next_id_ff;
                  we = 1'b1; waddr = free_idx;
                  wdata.flow_id = next_id_ff; wdata.src_addr = sa_ff;
                  wdata.dst_addr = da_ff; wdata.src_port = sp_ff; wdata.dst_port = dp_ff;
                  wdata.seq = seq_ff; wdata.ack = ack_ff; wdata.up = tft_pkg::HDR_BYTES;
                  wdata.down = '0; wdata.start_time = now_ff; wdata.fin_count = '0;
                  valid_in[free_idx] = 1'b1;
                  next_id_in = next_id_ff + 32'd1;
               end
            end else begin
               rcnt_in = '0; found_in = 1'b0; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit && (!found_ff || age > bage_ff)) begin
               found_in = 1'b1; best_in = cidx_ff; bage_in = age;
               bfwd_in = !is_synack && fwd_m;
            end
            if (rcnt_ff <= LAST) begin
               cidx_in = rcnt_ff[AW-1:0]; cval_in = 1'b1;
               rcnt_in = rcnt_ff + 1'b1;
            end else if (!cval_ff) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (!found_ff) begin
               rst_in = tft_pkg::ST_NOMATCH; rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               raddr = best_ff; state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // hold the address so rdata still shows the chosen slot in S_MOD
            raddr = best_ff; state_in = S_MOD;
         end
         S_MOD: begin
            rv_in = 1'b1; state_in = S_IDLE; rfn_in = rdata.flow_id; we = 1'b1;
            if (is_synack) begin
               upd.down = rdata.down + tft_pkg::HDR_BYTES;
               upd.seq = seq_ff; upd.ack = ack_ff;
               rst_in = tft_pkg::ST_SYNACK;
            end else if (is_fin) begin
               rst_in = tft_pkg::ST_FIN;
               if (rdata.ack == seq_ff || rdata.seq == seq_ff) begin
                  upd.seq = seq_ff; upd.ack = ack_ff;
                  if (bfwd_ff) upd.up = rdata.up + tft_pkg::HDR_BYTES;
                  else upd.down = rdata.down + tft_pkg::HDR_BYTES;
                  if (rdata.fin_count != 2'd3) upd.fin_count = rdata.fin_count + 2'd1;
               end
            end else begin
               if (rdata.seq == seq_ff || rdata.ack == seq_ff) begin
                  if (rdata.seq != seq_ff) begin
                     upd.seq = seq_ff; upd.ack = ack_ff;
                  end
                  addv = tft_pkg::HDR_BYTES +
                         ((payload > 0) ? 32'(unsigned'(payload[16:0])) : 32'd0);
                  if (bfwd_ff) upd.up = rdata.up + addv;
                  else upd.down = rdata.down + addv;
               end
               if (rdata.fin_count == 2'd2) begin
                  rst_in = tft_pkg::ST_CLOSED;
                  rsa_in = rdata.src_addr; rda_in = rdata.dst_addr;
                  rsp_in = rdata.src_port; rdp_in = rdata.dst_port;
                  rdur_in = now_ff - rdata.start_time;
                  rup_in = upd.up; rdn_in = upd.down;
                  valid_in[best_ff] = 1'b0;
               end else begin
                  rst_in = tft_pkg::ST_SEGMENT;
               end
            end
            wdata = upd;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; next_id_ff <= 32'd1;
         rv_ff <= 1'b0; cval_ff <= 1'b0; found_ff <= 1'b0; rcnt_ff <= '0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; next_id_ff <= next_id_in;
         rv_ff <= rv_in; cval_ff <= cval_in; found_ff <= found_in; rcnt_ff <= rcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         ihl_ff <= req_ip_header_words; thl_ff <= req_tcp_data_offset;
         tot_ff <= req_ip_total_length; sa_ff <= req_source_address;
         da_ff <= req_dest_address; sp_ff <= req_source_port; dp_ff <= req_dest_port;
         flg_ff <= req_tcp_flag_bits; seq_ff <= req_sequence_number;
         ack_ff <= req_ack_number; now_ff <= req_timestamp_s;
      end
      cidx_ff <= cidx_in; best_ff <= best_in; bage_ff <= bage_in; bfwd_ff <= bfwd_in;
      rst_ff <= rst_in; rfn_ff <= rfn_in; rsa_ff <= rsa_in; rda_ff <= rda_in;
      rsp_ff <= rsp_in; rdp_ff <= rdp_in; rdur_ff <= rdur_in; rup_ff <= rup_in;
      rdn_ff <= rdn_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_status = rst_ff;
   assign rsp_flow_number = rfn_ff;
   assign rsp_record_source_address = rsa_ff;
   assign rsp_record_dest_address = rda_ff;
   assign rsp_record_source_port = rsp_ff;
   assign rsp_record_dest_port = rdp_ff;
   assign rsp_duration_s = rdur_ff;
   assign rsp_bytes_up_total = rup_ff;
   assign rsp_bytes_down_total = rdn_ff;
endmodule
`default_nettype wire

// ===== design/tft_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module tft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
